// ----- hw/rtl/slt_pkg.sv -----
// Shared types, token kinds and word tables for the source line tokenizer.
package slt_pkg;

  localparam int COL_W        = 13;
  localparam int PREFIX_CHARS = 6;
  localparam int PREFIX_W     = 8 * PREFIX_CHARS;
  localparam int NUM_TYPES    = 13;
  localparam int NUM_KEYWORDS = 8;

  localparam logic [3:0] KIND_KEYWORD = 4'd0;
  localparam logic [3:0] KIND_IDENT   = 4'd1;
  localparam logic [3:0] KIND_NUMBER  = 4'd2;
  localparam logic [3:0] KIND_OPER    = 4'd3;
  localparam logic [3:0] KIND_PUNCT   = 4'd4;
  localparam logic [3:0] KIND_TYPE    = 4'd5;
  localparam logic [3:0] KIND_PTR     = 4'd6;
  localparam logic [3:0] KIND_DCOLON  = 4'd7;
  localparam logic [3:0] KIND_UNKNOWN = 4'd8;

  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_NL         = 8'd10;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_LPAREN     = 8'd40;
  localparam logic [7:0] CH_RPAREN     = 8'd41;
  localparam logic [7:0] CH_STAR       = 8'd42;
  localparam logic [7:0] CH_PLUS       = 8'd43;
  localparam logic [7:0] CH_COMMA      = 8'd44;
  localparam logic [7:0] CH_MINUS      = 8'd45;
  localparam logic [7:0] CH_SLASH      = 8'd47;
  localparam logic [7:0] CH_DIGIT_0    = 8'd48;
  localparam logic [7:0] CH_DIGIT_9    = 8'd57;
  localparam logic [7:0] CH_COLON      = 8'd58;
  localparam logic [7:0] CH_SEMI       = 8'd59;
  localparam logic [7:0] CH_EQUALS     = 8'd61;
  localparam logic [7:0] CH_UPPER_A    = 8'd65;
  localparam logic [7:0] CH_UPPER_Z    = 8'd90;
  localparam logic [7:0] CH_LBRACKET   = 8'd91;
  localparam logic [7:0] CH_RBRACKET   = 8'd93;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;
  localparam logic [7:0] CH_LOWER_A    = 8'd97;
  localparam logic [7:0] CH_LOWER_Z    = 8'd122;
  localparam logic [7:0] CH_LBRACE     = 8'd123;
  localparam logic [7:0] CH_RBRACE     = 8'd125;

  // Word prefixes hold the first character in the highest used byte,
  // so a name compares against its string literal, zero-extended.
  localparam logic [PREFIX_W-1:0] TYPE_NAME [NUM_TYPES] = '{
    PREFIX_W'("u8"),  PREFIX_W'("u16"), PREFIX_W'("u32"), PREFIX_W'("u64"),
    PREFIX_W'("u128"), PREFIX_W'("i8"), PREFIX_W'("i16"), PREFIX_W'("i32"),
    PREFIX_W'("i64"), PREFIX_W'("i128"), PREFIX_W'("f32"), PREFIX_W'("f64"),
    PREFIX_W'("bool")
  };
  localparam logic [2:0] TYPE_LEN [NUM_TYPES] = '{
    3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4
  };

  localparam logic [PREFIX_W-1:0] KEYWORD_NAME [NUM_KEYWORDS] = '{
    PREFIX_W'("pub"), PREFIX_W'("fn"), PREFIX_W'("return"), PREFIX_W'("if"),
    PREFIX_W'("else"), PREFIX_W'("elif"), PREFIX_W'("defer"), PREFIX_W'("test")
  };
  localparam logic [2:0] KEYWORD_LEN [NUM_KEYWORDS] = '{
    3'd3, 3'd2, 3'd6, 3'd2, 3'd4, 3'd4, 3'd5, 3'd4
  };

  typedef struct packed {
    logic [7:0]  ch;
    logic        line_end;
    logic [15:0] line_no;
  } item_t;

  typedef struct packed {
    logic [3:0]       token_kind;
    logic [15:0]      token_line;
    logic [COL_W-1:0] start_column;
    logic [COL_W-1:0] lexeme_length;
    logic [3:0]       word_index;
    logic [7:0]       token_char;
    logic             last;
  } token_t;

endpackage

// ----- hw/rtl/source_line_tokenizer.sv -----
// Source line tokenizer: character-at-a-time lexer with a small token queue.
// Tokens closed by a character are written into the token queue when the character is taken.
// Throughput: one character per cycle unless the input stalls, which it does while the
// four-entry token queue holds three or more tokens; a character may close two tokens.
// Reset: empties the token queue, returns the lexer to idle and sets the column to one.
// Lexer state updates in one pass per character; the queue is the only storage on the output.
module source_line_tokenizer #(
  parameter int MAX_LINE_CHARS = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  slt_pkg::item_t  item,
  output logic            token_valid,
  input  logic            token_stall,
  output slt_pkg::token_t token
);
  import slt_pkg::*;

  // Counters must hold MAX_LINE_CHARS itself, since they saturate there.
  localparam int               RUN_W       = $clog2(MAX_LINE_CHARS + 1);
  localparam logic [RUN_W-1:0] RUN_MAX     = RUN_W'(MAX_LINE_CHARS);
  localparam int               QUEUE_DEPTH = 4;
  localparam int               PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int               CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_TYPE_WAIT,
    MODE_COLON,
    MODE_SLASH,
    MODE_COMMENT
  } mode_t;

  typedef struct packed {
    logic       type_hit;
    logic       kw_hit;
    logic [3:0] idx;
  } word_class_t;

  // Character classes.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
  endfunction

  function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
    return (v < RUN_MAX) ? v + RUN_W'(1) : RUN_MAX;
  endfunction

  // Match a finished word against the type names first, then the keywords.
  function automatic word_class_t classify(input logic [PREFIX_W-1:0] p,
                                           input logic [RUN_W-1:0] n);
    word_class_t r;
    r = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (p == TYPE_NAME[i] && n == RUN_W'(TYPE_LEN[i])) begin
        r.type_hit = 1'b1;
        r.idx      = 4'(i);
      end
    end
    if (!r.type_hit) begin
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
        if (p == KEYWORD_NAME[i] && n == RUN_W'(KEYWORD_LEN[i])) begin
          r.kw_hit = 1'b1;
          r.idx    = 4'(i);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [RUN_W-1:0] type_len(input logic [3:0] idx);
    return (idx < 4'(NUM_TYPES)) ? RUN_W'(TYPE_LEN[idx]) : RUN_W'(TYPE_LEN[0]);
  endfunction

  function automatic token_t mk_tok(input logic [3:0] kind, input logic [15:0] line,
                                    input logic [RUN_W-1:0] col, input logic [RUN_W-1:0] len,
                                    input logic [3:0] idx, input logic [7:0] c);
    token_t r;
    r.token_kind    = kind;
    r.token_line    = line;
    r.start_column  = COL_W'(col);
    r.lexeme_length = COL_W'(len);
    r.word_index    = idx;
    r.token_char    = c;
    r.last          = 1'b0;
    return r;
  endfunction

  // Lexer state.
  mode_t                mode, mode_next;
  logic [PREFIX_W-1:0]  prefix, prefix_next;
  logic [RUN_W-1:0]     run_len, run_len_next;
  logic [RUN_W-1:0]     run_start, run_start_next;
  logic [RUN_W-1:0]     column, column_next;
  logic [3:0]           type_idx, type_idx_next;

  // Tokens closed by the current character (never more than two).
  token_t               tok_pair [2];
  logic [1:0]           n_tok;

  // Token queue.
  token_t               queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 item_take, token_take;
  logic [CNT_W-1:0]     push_cnt;

  // Single pass over one character: the mode checks run in the same order
  // as a software lexer would, each later check seeing the mode that the
  // earlier ones left, then the line end flushes whatever is still pending.
  always_comb begin
    logic        used;
    logic [7:0]  c;
    logic [15:0] ln;
    word_class_t wc;
    word_class_t fc;
    c              = item.ch;
    ln             = item.line_no;
    used           = 1'b0;
    mode_next      = mode;
    prefix_next    = prefix;
    run_len_next   = run_len;
    run_start_next = run_start;
    type_idx_next  = type_idx;
    column_next    = sat_inc(column);
    n_tok          = 2'd0;
    tok_pair[0]    = '0;
    tok_pair[1]    = '0;
    wc             = classify(prefix, run_len);
    fc             = '0;

    // Extend the word, or close it.
    if (mode_next == MODE_WORD) begin
      if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
        if (run_len_next < RUN_W'(PREFIX_CHARS)) begin
          prefix_next = {prefix_next[PREFIX_W-9:0], c};
        end
        run_len_next = sat_inc(run_len_next);
        used         = 1'b1;
      end else if (wc.type_hit) begin
        // Hold the type back: a following '*' turns it into a pointer type.
        type_idx_next = wc.idx;
        mode_next     = MODE_TYPE_WAIT;
      end else begin
        tok_pair[n_tok[0]] = mk_tok(wc.kw_hit ? KIND_KEYWORD : KIND_IDENT, ln, run_start_next,
                                    run_len_next, wc.kw_hit ? wc.idx : 4'd0, 8'd0);
        n_tok     = n_tok + 2'd1;
        mode_next = MODE_IDLE;
      end
    end

    if (!used && mode_next == MODE_TYPE_WAIT) begin
      if (is_space(c)) begin
        run_len_next = sat_inc(run_len_next);
        used         = 1'b1;
      end else if (c == CH_STAR) begin
        tok_pair[n_tok[0]] = mk_tok(KIND_PTR, ln, run_start_next, sat_inc(run_len_next),
                                    type_idx_next, 8'd0);
        n_tok     = n_tok + 2'd1;
        mode_next = MODE_IDLE;
        used      = 1'b1;
      end else begin
        tok_pair[n_tok[0]] = mk_tok(KIND_TYPE, ln, run_start_next, type_len(type_idx_next),
                                    type_idx_next, 8'd0);
        n_tok     = n_tok + 2'd1;
        mode_next = MODE_IDLE;
      end
    end

    if (!used && mode_next == MODE_NUMBER) begin
      if (is_digit(c)) begin
        run_len_next = sat_inc(run_len_next);
        used         = 1'b1;
      end else begin
        tok_pair[n_tok[0]] = mk_tok(KIND_NUMBER, ln, run_start_next, run_len_next, 4'd0, 8'd0);
        n_tok     = n_tok + 2'd1;
        mode_next = MODE_IDLE;
      end
    end

    if (!used && mode_next == MODE_COLON) begin
      if (c == CH_COLON) begin
        tok_pair[n_tok[0]] = mk_tok(KIND_DCOLON, ln, run_start_next, RUN_W'(2), 4'd0, 8'd0);
        used = 1'b1;
      end else begin
        tok_pair[n_tok[0]] = mk_tok(KIND_UNKNOWN, ln, run_start_next, RUN_W'(1), 4'd0,
                                    CH_COLON);
      end
      n_tok     = n_tok + 2'd1;
      mode_next = MODE_IDLE;
    end

    if (!used && mode_next == MODE_SLASH) begin
      if (c == CH_SLASH) begin
        mode_next = MODE_COMMENT;
        used      = 1'b1;
      end else begin
        tok_pair[n_tok[0]] = mk_tok(KIND_OPER, ln, run_start_next, RUN_W'(1), 4'd0, CH_SLASH);
        n_tok     = n_tok + 2'd1;
        mode_next = MODE_IDLE;
      end
    end

    if (!used && mode_next == MODE_COMMENT) begin
      if (c == CH_NL) begin
        mode_next = MODE_IDLE;
      end
      used = 1'b1;
    end

    // Start a new lexeme, or emit a one-character token at once.
    if (!used) begin
      if (is_space(c)) begin
        mode_next = mode_next;
      end else if (c == CH_COLON) begin
        run_start_next = column;
        run_len_next   = RUN_W'(1);
        mode_next      = MODE_COLON;
      end else if (is_alpha(c)) begin
        run_start_next = column;
        run_len_next   = RUN_W'(1);
        prefix_next    = PREFIX_W'(c);
        mode_next      = MODE_WORD;
      end else if (is_digit(c)) begin
        run_start_next = column;
        run_len_next   = RUN_W'(1);
        mode_next      = MODE_NUMBER;
      end else if (c == CH_SLASH) begin
        run_start_next = column;
        run_len_next   = RUN_W'(1);
        mode_next      = MODE_SLASH;
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_EQUALS) begin
        tok_pair[n_tok[0]] = mk_tok(KIND_OPER, ln, column, RUN_W'(1), 4'd0, c);
        n_tok = n_tok + 2'd1;
      end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN || c == CH_RPAREN ||
                   c == CH_LBRACKET || c == CH_RBRACKET || c == CH_SEMI || c == CH_COMMA) begin
        tok_pair[n_tok[0]] = mk_tok(KIND_PUNCT, ln, column, RUN_W'(1), 4'd0, c);
        n_tok = n_tok + 2'd1;
      end else begin
        tok_pair[n_tok[0]] = mk_tok(KIND_UNKNOWN, ln, column, RUN_W'(1), 4'd0, c);
        n_tok = n_tok + 2'd1;
      end
    end

    // Line end: flush the pending lexeme; a pending type goes out plain.
    if (item.line_end) begin
      fc = classify(prefix_next, run_len_next);
      case (mode_next)
        MODE_WORD: begin
          if (fc.type_hit) begin
            tok_pair[n_tok[0]] = mk_tok(KIND_TYPE, ln, run_start_next, run_len_next, fc.idx,
                                        8'd0);
          end else begin
            tok_pair[n_tok[0]] = mk_tok(fc.kw_hit ? KIND_KEYWORD : KIND_IDENT, ln,
                                        run_start_next, run_len_next,
                                        fc.kw_hit ? fc.idx : 4'd0, 8'd0);
          end
          n_tok = n_tok + 2'd1;
        end
        MODE_TYPE_WAIT: begin
          tok_pair[n_tok[0]] = mk_tok(KIND_TYPE, ln, run_start_next, type_len(type_idx_next),
                                      type_idx_next, 8'd0);
          n_tok = n_tok + 2'd1;
        end
        MODE_NUMBER: begin
          tok_pair[n_tok[0]] = mk_tok(KIND_NUMBER, ln, run_start_next, run_len_next, 4'd0,
                                      8'd0);
          n_tok = n_tok + 2'd1;
        end
        MODE_COLON: begin
          tok_pair[n_tok[0]] = mk_tok(KIND_UNKNOWN, ln, run_start_next, RUN_W'(1), 4'd0,
                                      CH_COLON);
          n_tok = n_tok + 2'd1;
        end
        MODE_SLASH: begin
          tok_pair[n_tok[0]] = mk_tok(KIND_OPER, ln, run_start_next, RUN_W'(1), 4'd0,
                                      CH_SLASH);
          n_tok = n_tok + 2'd1;
        end
        default: begin
          n_tok = n_tok;
        end
      endcase
      mode_next   = MODE_IDLE;
      column_next = RUN_W'(1);
    end

    // Mark the final token of this character.
    if (n_tok == 2'd1) begin
      tok_pair[0].last = 1'b1;
    end else if (n_tok == 2'd2) begin
      tok_pair[1].last = 1'b1;
    end
  end

  // Handshakes. Stall depends on the queue fill alone, so the input side
  // never waits on the output stall in the same cycle.
  assign item_stall  = count > CNT_W'(QUEUE_DEPTH - 2);
  assign item_take   = item_valid && !item_stall;
  assign token_valid = count != '0;
  assign token_take  = token_valid && !token_stall;
  assign token       = queue[rd_ptr];
  assign push_cnt    = item_take ? CNT_W'(n_tok) : '0;

  always_ff @(posedge clk) begin
    // Queue storage carries no reset; only its pointers and fill do.
    if (item_take && n_tok != 2'd0) begin
      queue[wr_ptr] <= tok_pair[0];
    end
    if (item_take && n_tok == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= tok_pair[1];
    end

    if (rst) begin
      mode      <= MODE_IDLE;
      prefix    <= '0;
      run_len   <= '0;
      run_start <= '0;
      column    <= RUN_W'(1);
      type_idx  <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (item_take) begin
        mode      <= mode_next;
        prefix    <= prefix_next;
        run_len   <= run_len_next;
        run_start <= run_start_next;
        column    <= column_next;
        type_idx  <= type_idx_next;
        wr_ptr    <= wr_ptr + PTR_W'(n_tok);
      end
      if (token_take) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + push_cnt - CNT_W'(token_take);
    end
  end

endmodule

// ----- hw/rtl/slt_checker.sv -----
// Port-level assertions for the source line tokenizer, bound to the top level.
module slt_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_stall,
  input slt_pkg::item_t  item,
  input logic            token_valid,
  input logic            token_stall,
  input slt_pkg::token_t token
);
  import slt_pkg::*;

  // Reset empties the token queue.
  assert property (@(posedge clk) rst |=> !token_valid)
    else $error("token offered right after reset");

  // A stalled token request stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token))
    else $error("stalled token request changed");

  // The input only stalls while tokens are waiting to drain.
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> token_valid)
    else $error("input stalled with no tokens pending");

  // One-character tokens carry a length of one and a word index of zero.
  assert property (@(posedge clk) disable iff (rst)
    token_valid && (token.token_kind == KIND_OPER || token.token_kind == KIND_PUNCT ||
                    token.token_kind == KIND_UNKNOWN)
    |-> token.lexeme_length == 13'd1 && token.word_index == 4'd0)
    else $error("single-character token with wrong length or index");

  // Word, type, pointer, number and double-colon tokens carry no character.
  assert property (@(posedge clk) disable iff (rst)
    token_valid && !(token.token_kind == KIND_OPER || token.token_kind == KIND_PUNCT ||
                     token.token_kind == KIND_UNKNOWN)
    |-> token.token_char == 8'd0)
    else $error("multi-character token carries a character");

endmodule

bind source_line_tokenizer slt_checker u_slt_checker (.*);

// ----- verif/tb_source_line_tokenizer.sv -----
// Self-checking testbench for the source line tokenizer: directed and random text.
module tb_source_line_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  // Column and run counters stop at this value, as in the block's default build.
  localparam int LINE_LIMIT = 4096;
  // Give up on a run that has not finished by this many clock cycles.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles to linger once nothing is outstanding.
  localparam int SETTLE_CYCLES = 4;
  // Mismatch lines printed before the rest are only counted.
  localparam int MAX_REPORTS = 40;

  // Lexer modes of the predictor.
  typedef enum logic [2:0] {
    LX_IDLE,
    LX_WORD,
    LX_NUMBER,
    LX_TYPE_WAIT,
    LX_COLON,
    LX_SLASH,
    LX_COMMENT
  } lex_mode_e;

  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   item_valid  = 1'b0;
  logic   item_stall;
  item_t  item        = '0;
  logic   token_valid;
  logic   token_stall = 1'b0;
  token_t token;

  // Word tables, in index order of the token's word_index field.
  string type_words [13] = '{"u8", "u16", "u32", "u64", "u128", "i8", "i16", "i32",
                             "i64", "i128", "f32", "f64", "bool"};
  string keyword_words [8] = '{"pub", "fn", "return", "if", "else", "elif", "defer", "test"};
  logic [7:0] oper_chars [4]  = '{CH_PLUS, CH_MINUS, CH_STAR, CH_EQUALS};
  logic [7:0] punct_chars [8] = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
                                  CH_LBRACKET, CH_RBRACKET, CH_SEMI, CH_COMMA};

  // Predictor state: our own copy of the lexer.
  lex_mode_e        lx_mode     = LX_IDLE;
  logic [47:0]      lx_prefix   = '0;
  logic [COL_W-1:0] lx_run_len  = '0;
  logic [COL_W-1:0] lx_run_col  = '0;
  logic [COL_W-1:0] lx_col      = COL_W'(1);
  logic [3:0]       lx_type_idx = '0;
  logic [15:0]      lx_line;

  token_t     char_tokens [$];  // tokens raised by the request being lexed
  token_t     lexed_tokens [$]; // tokens still to come out of the block, oldest first
  logic [7:0] line_text [$];    // characters of the line being composed

  int send_idle_pct     = 0;
  int token_stall_pct   = 0;
  int stall_hold_cycles = 0;
  int mismatch_count    = 0;
  int cycle_count       = 0;

  source_line_tokenizer i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
  endfunction

  function automatic logic [COL_W-1:0] sat_inc(input logic [COL_W-1:0] v);
    return (v < LINE_LIMIT) ? v + COL_W'(1) : COL_W'(LINE_LIMIT);
  endfunction

  // Pack a name the same way the predictor packs the start of a word.
  function automatic logic [47:0] packed_word(input string s);
    logic [47:0] w;
    int          i;
    w = '0;
    for (i = 0; i < s.len(); i++) w = {w[39:0], s[i]};
    return w;
  endfunction

  task automatic push_token(input logic [3:0] kind, input logic [COL_W-1:0] col,
                            input logic [COL_W-1:0] len, input logic [3:0] idx,
                            input logic [7:0] c);
    token_t t;
    t.token_kind    = kind;
    t.token_line    = lx_line;
    t.start_column  = col;
    t.lexeme_length = len;
    t.word_index    = idx;
    t.token_char    = c;
    t.last          = 1'b0;
    if (char_tokens.size() < 3) char_tokens.push_back(t);
  endtask

  // Classify a finished word; a type waits for a possible '*' unless the line ends.
  task automatic close_word(input bit at_line_end);
    int type_hit;
    int key_hit;
    int i;
    type_hit = -1;
    key_hit  = -1;
    for (i = 0; i < 13; i++)
      if (type_hit < 0 && lx_run_len == COL_W'(type_words[i].len()) &&
          lx_prefix == packed_word(type_words[i])) type_hit = i;
    for (i = 0; i < 8; i++)
      if (key_hit < 0 && lx_run_len == COL_W'(keyword_words[i].len()) &&
          lx_prefix == packed_word(keyword_words[i])) key_hit = i;
    if (type_hit >= 0) begin
      if (at_line_end) begin
        push_token(KIND_TYPE, lx_run_col, lx_run_len, 4'(type_hit), 8'h00);
        lx_mode = LX_IDLE;
      end else begin
        lx_type_idx = 4'(type_hit);
        lx_mode     = LX_TYPE_WAIT;
      end
    end else if (key_hit >= 0) begin
      push_token(KIND_KEYWORD, lx_run_col, lx_run_len, 4'(key_hit), 8'h00);
      lx_mode = LX_IDLE;
    end else begin
      push_token(KIND_IDENT, lx_run_col, lx_run_len, 4'h0, 8'h00);
      lx_mode = LX_IDLE;
    end
  endtask

  task automatic close_type();
    push_token(KIND_TYPE, lx_run_col, COL_W'(type_words[lx_type_idx].len()), lx_type_idx,
               8'h00);
    lx_mode = LX_IDLE;
  endtask

  // Lex one accepted character and queue the tokens it closes.
  task automatic lex_char(input item_t req);
    logic [7:0]       c;
    logic [COL_W-1:0] col;
    bit               used;
    int               i;
    c       = req.ch;
    col     = lx_col;
    used    = 1'b0;
    lx_line = req.line_no;
    char_tokens.delete();

    if (lx_mode == LX_WORD) begin
      if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
        if (lx_run_len < PREFIX_CHARS) lx_prefix = {lx_prefix[39:0], c};
        lx_run_len = sat_inc(lx_run_len);
        used       = 1'b1;
      end else begin
        close_word(1'b0);
      end
    end
    if (!used && lx_mode == LX_TYPE_WAIT) begin
      if (is_space(c)) begin
        lx_run_len = sat_inc(lx_run_len);
        used       = 1'b1;
      end else if (c == CH_STAR) begin
        // the star belongs to the pointer type and is not seen again
        push_token(KIND_PTR, lx_run_col, sat_inc(lx_run_len), lx_type_idx, 8'h00);
        lx_mode = LX_IDLE;
        used    = 1'b1;
      end else begin
        close_type();
      end
    end
    if (!used && lx_mode == LX_NUMBER) begin
      if (is_digit(c)) begin
        lx_run_len = sat_inc(lx_run_len);
        used       = 1'b1;
      end else begin
        push_token(KIND_NUMBER, lx_run_col, lx_run_len, 4'h0, 8'h00);
        lx_mode = LX_IDLE;
      end
    end
    if (!used && lx_mode == LX_COLON) begin
      if (c == CH_COLON) begin
        push_token(KIND_DCOLON, lx_run_col, COL_W'(2), 4'h0, 8'h00);
        used = 1'b1;
      end else begin
        push_token(KIND_UNKNOWN, lx_run_col, COL_W'(1), 4'h0, CH_COLON);
      end
      lx_mode = LX_IDLE;
    end
    if (!used && lx_mode == LX_SLASH) begin
      if (c == CH_SLASH) begin
        lx_mode = LX_COMMENT;
        used    = 1'b1;
      end else begin
        push_token(KIND_OPER, lx_run_col, COL_W'(1), 4'h0, CH_SLASH);
        lx_mode = LX_IDLE;
      end
    end
    if (!used && lx_mode == LX_COMMENT) begin
      if (c == CH_NL) lx_mode = LX_IDLE;
      used = 1'b1;
    end
    if (!used) begin
      if (is_space(c)) begin
        // skip whitespace
      end else if (c == CH_COLON) begin
        lx_run_col = col;
        lx_run_len = COL_W'(1);
        lx_mode    = LX_COLON;
      end else if (is_alpha(c)) begin
        lx_run_col = col;
        lx_run_len = COL_W'(1);
        lx_prefix  = {40'h0, c};
        lx_mode    = LX_WORD;
      end else if (is_digit(c)) begin
        lx_run_col = col;
        lx_run_len = COL_W'(1);
        lx_mode    = LX_NUMBER;
      end else if (c == CH_SLASH) begin
        lx_run_col = col;
        lx_run_len = COL_W'(1);
        lx_mode    = LX_SLASH;
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_EQUALS) begin
        push_token(KIND_OPER, col, COL_W'(1), 4'h0, c);
      end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN || c == CH_RPAREN ||
                   c == CH_LBRACKET || c == CH_RBRACKET || c == CH_SEMI || c == CH_COMMA) begin
        push_token(KIND_PUNCT, col, COL_W'(1), 4'h0, c);
      end else begin
        push_token(KIND_UNKNOWN, col, COL_W'(1), 4'h0, c);
      end
    end

    lx_col = sat_inc(lx_col);

    // Flush whatever is still open at the end of the line; columns restart.
    if (req.line_end) begin
      case (lx_mode)
        LX_WORD:      close_word(1'b1);
        LX_TYPE_WAIT: close_type();
        LX_NUMBER:    push_token(KIND_NUMBER, lx_run_col, lx_run_len, 4'h0, 8'h00);
        LX_COLON:     push_token(KIND_UNKNOWN, lx_run_col, COL_W'(1), 4'h0, CH_COLON);
        LX_SLASH:     push_token(KIND_OPER, lx_run_col, COL_W'(1), 4'h0, CH_SLASH);
        default:      ;
      endcase
      lx_mode = LX_IDLE;
      lx_col  = COL_W'(1);
    end

    if (char_tokens.size() > 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
    for (i = 0; i < char_tokens.size(); i++) lexed_tokens.push_back(char_tokens[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Token side: stall pattern and checking
  // ---------------------------------------------------------------------------

  // Hold the token port off for a counted stretch, else stall at the phase's rate.
  always @(posedge clk) begin
    if (stall_hold_cycles > 0) begin
      stall_hold_cycles--;
      token_stall <= 1'b1;
    end else begin
      token_stall <= ($urandom_range(0, 99) < token_stall_pct);
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] token mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Compare every accepted token with the oldest predicted one.
  always @(posedge clk) begin
    token_t want;
    if (!rst && token_valid && !token_stall) begin
      if (lexed_tokens.size() == 0) begin
        report_mismatch("token with nothing predicted");
      end else begin
        want = lexed_tokens.pop_front();
        check_field("token_kind", 16'(token.token_kind), 16'(want.token_kind));
        check_field("token_line", token.token_line, want.token_line);
        check_field("start_column", 16'(token.start_column), 16'(want.start_column));
        check_field("lexeme_length", 16'(token.lexeme_length), 16'(want.lexeme_length));
        check_field("word_index", 16'(token.word_index), 16'(want.word_index));
        check_field("token_char", 16'(token.token_char), 16'(want.token_char));
        check_field("last", 16'(token.last), 16'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Character side: sending and line composition
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at the phase's rate; valid stays up afterwards.
  task automatic send_char(input item_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    lex_char(req);
  endtask

  // Send the composed line; characters from switch_at on carry the second line number.
  task automatic send_line(input logic [15:0] first_no, input logic [15:0] second_no,
                           input int switch_at);
    item_t req;
    int    i;
    for (i = 0; i < line_text.size(); i++) begin
      req.ch       = line_text[i];
      req.line_end = (i == line_text.size() - 1);
      req.line_no  = (i < switch_at) ? first_no : second_no;
      send_char(req);
    end
  endtask

  // Drop valid and wait until every predicted token has come out.
  task automatic wait_for_tokens();
    item_valid <= 1'b0;
    while (lexed_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_text.push_back(s[i]);
  endtask

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? CH_UPPER_A + 8'(r) : CH_LOWER_A + 8'(r - 26);
  endfunction

  function automatic logic [7:0] random_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return random_letter();
    if (r < 62) return CH_DIGIT_0 + 8'(r - 52);
    return CH_UNDERSCORE;
  endfunction

  function automatic logic [7:0] random_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  // Build a line out of lexeme-shaped pieces, with the odd raw byte thrown in.
  task automatic compose_random_line();
    int pieces;
    int p;
    int k;
    int n;
    int r;
    line_text.delete();
    pieces = $urandom_range(2, 6);
    for (p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 14))
        0: push_text(keyword_words[$urandom_range(0, 7)]);
        1: push_text(type_words[$urandom_range(0, 12)]);
        2: begin
          // pointer type, with or without spaces before the star
          push_text(type_words[$urandom_range(0, 12)]);
          n = $urandom_range(0, 2);
          for (k = 0; k < n; k++) line_text.push_back(random_space());
          line_text.push_back(CH_STAR);
        end
        3: begin
          line_text.push_back(random_letter());
          n = $urandom_range(0, 8);
          for (k = 0; k < n; k++) line_text.push_back(random_word_char());
        end
        4: begin
          n = $urandom_range(1, 5);
          for (k = 0; k < n; k++) line_text.push_back(CH_DIGIT_0 + 8'($urandom_range(0, 9)));
        end
        5: push_text("::");
        6: line_text.push_back(CH_COLON);
        7: line_text.push_back(oper_chars[$urandom_range(0, 3)]);
        8: line_text.push_back(punct_chars[$urandom_range(0, 7)]);
        9: begin
          // comment with raw content, closed by a newline half the time
          push_text("//");
          n = $urandom_range(0, 4);
          for (k = 0; k < n; k++) line_text.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1)) line_text.push_back(CH_NL);
        end
        10: line_text.push_back(random_space());
        11: begin
          r = $urandom_range(0, 3);
          case (r)
            0:       line_text.push_back(8'h00);
            1:       line_text.push_back(CH_UNDERSCORE);
            2:       line_text.push_back(8'($urandom_range(128, 255)));
            default: push_text("#");
          endcase
        end
        12: line_text.push_back(CH_SLASH);
        13: line_text.push_back(8'($urandom_range(0, 255)));
        default: begin
          // near miss: a known word that runs on into an identifier
          if ($urandom_range(0, 1)) push_text(keyword_words[$urandom_range(0, 7)]);
          else push_text(type_words[$urandom_range(0, 12)]);
          line_text.push_back(random_word_char());
        end
      endcase
      if ($urandom_range(0, 1)) line_text.push_back(random_space());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-written lines for the awkward corners of the lexer.
  task automatic test_directed_cases();
    send_idle_pct   = 0;
    token_stall_pct = 0;
    // pointer type across a space, then a lone colon left open at the line end
    line_text.delete();
    push_text("i128 *:");
    send_line(16'h0000, 16'h0000, line_text.size());
    // type closed by a slash, and the slash flushed as an operator
    line_text.delete();
    push_text("u8/");
    send_line(16'hFFFF, 16'hFFFF, line_text.size());
    // identifier takes the line number of the request that closes it;
    // the newline ends the comment and the digit is flushed as a number
    line_text.delete();
    push_text("x//");
    line_text.push_back(CH_NL);
    push_text("9");
    send_line(16'h1234, 16'h5678, 1);
    // lone underscore, NUL and a high byte are unknown; comment runs to the line end
    line_text.delete();
    line_text.push_back(CH_UNDERSCORE);
    line_text.push_back(8'h00);
    line_text.push_back(8'hFF);
    push_text("//");
    send_line(16'h00FF, 16'h00FF, line_text.size());
    // the next line starts outside the comment
    line_text.delete();
    push_text("*+");
    send_line(16'hFF00, 16'hFF00, line_text.size());
    wait_for_tokens();
  endtask

  // Runs longer than the kept word prefix: a keyword that runs on, and a long number.
  task automatic test_long_runs();
    int k;
    send_idle_pct   = 0;
    token_stall_pct = 0;
    line_text.delete();
    push_text("return");
    for (k = 0; k < 8; k++) push_text("1");
    line_text.push_back(CH_PLUS);
    line_text.push_back(CH_SEMI);
    send_line(16'h2468, 16'h2468, line_text.size());
    line_text.delete();
    for (k = 0; k < 12; k++) push_text("7");
    send_line(16'h1357, 16'h1357, line_text.size());
    wait_for_tokens();
  endtask

  // Random lines under one pattern of sender idling and receiver stalls.
  task automatic test_random_text(input int idle_pct, input int stall_pct, input int count);
    int          sent;
    int          switch_at;
    logic [15:0] line_no;
    send_idle_pct   = idle_pct;
    token_stall_pct = stall_pct;
    sent            = 0;
    while (sent < count) begin
      compose_random_line();
      line_no   = 16'($urandom_range(0, 65535));
      switch_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, line_text.size() - 1)
                                              : line_text.size();
      send_line(line_no, 16'($urandom_range(0, 65535)), switch_at);
      sent += line_text.size();
    end
    wait_for_tokens();
  endtask

  // Hold the token port off while dense text keeps coming, so the queue fills
  // and the character port stalls; then release and drain.
  task automatic test_output_backpressure();
    int k;
    send_idle_pct     = 0;
    token_stall_pct   = 0;
    stall_hold_cycles = 200;
    line_text.delete();
    for (k = 0; k < 15; k++) begin
      line_text.push_back(random_letter());
      line_text.push_back(punct_chars[$urandom_range(0, 7)]);
    end
    send_line(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              line_text.size());
    wait_for_tokens();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_long_runs();
    test_random_text(0, 0, 30);
    test_random_text(53, 0, 30);
    test_random_text(0, 53, 30);
    test_random_text(33, 33, 30);
    test_output_backpressure();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/slt_pkg.sv
hw/rtl/source_line_tokenizer.sv
hw/rtl/slt_checker.sv
verif/tb_source_line_tokenizer.sv
